[hdl/assert_macros.svh]
// Assertion helpers used by the checker file npf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on a clocked property.
`define NPF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on a clocked property.
`define NPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/npf_pkg.sv]
`default_nettype none

package npf_pkg;

  typedef enum logic [1:0] {
    MODE_EVEN   = 2'd0,
    MODE_ODD    = 2'd1,
    MODE_PRIME  = 2'd2,
    MODE_SQUARE = 2'd3
  } filter_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SQRT,
    S_SQ_TEST,
    S_DIV_CHECK,
    S_DIV_STEP,
    S_DIV_TEST,
    S_DONE
  } npf_state_t;

  typedef struct packed {
    logic load;       // latch the input word, arm the root unit
    logic div_start;  // clear remainder, arm the bit counter
    logic div_shift;  // one restoring-division step
    logic div_next;   // advance to the next trial divisor
    logic sqrt_step;  // one square-root digit
    logic emit;       // load the output register
  } npf_cmd_t;

  typedef struct packed {
    filter_mode_t mode;
    logic         odd;
    logic         below_two;
    logic         sq_gt_v;     // divisor squared exceeds the word
    logic         rem_zero;
    logic         step_last;
    logic         sqrt_exact;  // root remainder is zero
    logic         out_free;
  } npf_status_t;

endpackage

`default_nettype wire

[hdl/npf_ctrl.sv]
`default_nettype none

module npf_ctrl
  import npf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  npf_status_t status,
  output npf_cmd_t    cmd
);

  npf_state_t state, state_next;
  logic       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (status.mode)
          MODE_EVEN: begin
            pass_next  = !status.odd;
            state_next = S_DONE;
          end
          MODE_ODD: begin
            pass_next  = status.odd;
            state_next = S_DONE;
          end
          MODE_PRIME: begin
            if (status.below_two) begin
              pass_next  = 1'b0;
              state_next = S_DONE;
            end else begin
              state_next = S_DIV_CHECK;
            end
          end
          MODE_SQUARE: begin
            state_next = S_SQRT;
          end
        endcase
      end
      S_SQRT: begin
        if (status.step_last) state_next = S_SQ_TEST;
      end
      S_SQ_TEST: begin
        pass_next  = status.sqrt_exact;
        state_next = S_DONE;
      end
      S_DIV_CHECK: begin
        if (status.sq_gt_v) begin
          pass_next  = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        if (status.step_last) state_next = S_DIV_TEST;
      end
      S_DIV_TEST: begin
        if (status.rem_zero) begin
          pass_next  = 1'b0;
          state_next = S_DONE;
        end else begin
          state_next = S_DIV_CHECK;
        end
      end
      S_DONE: begin
        if (!pass || status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SQRT:      cmd.sqrt_step = 1'b1;
      S_DIV_CHECK: cmd.div_start = !status.sq_gt_v;
      S_DIV_STEP:  cmd.div_shift = 1'b1;
      S_DIV_TEST:  cmd.div_next  = !status.rem_zero;
      S_DONE:      cmd.emit      = pass && status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/npf_dp.sv]
`default_nettype none

module npf_dp
  import npf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic [VALUE_BITS-1:0] value,
  output logic [VALUE_BITS-1:0] passed_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  npf_cmd_t              cmd,
  output npf_status_t           status
);

  localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
  localparam int SQW       = 2 * ROOT_BITS;
  localparam int CNT_BITS  = $clog2(VALUE_BITS + 1);
  localparam logic [SQW-1:0] ONE_INIT = SQW'(1) << (SQW - 2);

  filter_mode_t          filter_mode;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS:0]   square;     // divisor * divisor, tracked incrementally
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] shv;        // dividend bits, MSB first
  logic [CNT_BITS-1:0]   cnt;
  logic [SQW-1:0]        op;
  logic [SQW-1:0]        res;
  logic [SQW-1:0]        one;

  logic [VALUE_BITS:0]   rem_shifted;
  logic [VALUE_BITS:0]   rem_diff;
  logic                  rem_ge;
  logic [VALUE_BITS-1:0] rem_next;
  logic [VALUE_BITS:0]   square_next;
  logic [SQW:0]          rt_sum;
  logic [SQW:0]          rt_diff;
  logic                  rt_take;
  logic [SQW-1:0]        res_half;
  logic                  out_free;

  // restoring remainder step
  assign rem_shifted = {rem, shv[VALUE_BITS-1]};
  assign rem_ge      = rem_shifted >= {1'b0, divisor};
  assign rem_diff    = rem_shifted - {1'b0, divisor};
  assign rem_next    = rem_ge ? rem_diff[VALUE_BITS-1:0] : rem_shifted[VALUE_BITS-1:0];

  // (d+1)^2 = d^2 + 2d + 1
  assign square_next = square + {divisor, 1'b1};

  // digit-by-digit square root
  assign rt_sum   = {1'b0, res} + {1'b0, one};
  assign rt_take  = {1'b0, op} >= rt_sum;
  assign rt_diff  = {1'b0, op} - rt_sum;
  assign res_half = res >> 1;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_EVEN;
    end else if (cfg_we) begin
      filter_mode <= filter_mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= value;
      op  <= SQW'(value);
      res <= '0;
      one <= ONE_INIT;
      cnt <= CNT_BITS'(ROOT_BITS);
      divisor <= VALUE_BITS'(2);
      square  <= (VALUE_BITS + 1)'(4);
    end
    if (cmd.sqrt_step) begin
      if (rt_take) begin
        op  <= rt_diff[SQW-1:0];
        res <= res_half + one;
      end else begin
        res <= res_half;
      end
      one <= one >> 2;
      cnt <= cnt - CNT_BITS'(1);
    end
    if (cmd.div_start) begin
      rem <= '0;
      shv <= v;
      cnt <= CNT_BITS'(VALUE_BITS);
    end
    if (cmd.div_shift) begin
      rem <= rem_next;
      shv <= shv << 1;
      cnt <= cnt - CNT_BITS'(1);
    end
    if (cmd.div_next) begin
      divisor <= divisor + VALUE_BITS'(1);
      square  <= square_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) passed_value <= v;
  end

  always_comb begin
    status.mode       = filter_mode;
    status.odd        = v[0];
    status.below_two  = v < VALUE_BITS'(2);
    status.sq_gt_v    = square > {1'b0, v};
    status.rem_zero   = rem == '0;
    status.step_last  = cnt == CNT_BITS'(1);
    status.sqrt_exact = op == '0;
    status.out_free   = out_free;
  end

endmodule

`default_nettype wire

[hdl/number_property_filter.sv]
// number_property_filter: passes an input word through only when it has the
// property chosen by filter_mode (0 even, 1 odd, 2 prime, 3 perfect square).
// Channels: input word on value with in_valid/in_stall, result word on
// passed_value with out_valid/out_stall; a word moves when valid is high and
// stall is low. Words that fail the test are dropped, nothing is emitted.
// Config: filter_mode is written by cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block does not enforce it.
// One word at a time (N = VALUE_BITS, K = ceil(N/2)):
//   even/odd: accept, dispatch, then result load in the done state.
//   square:   K root digits, one root digit per cycle, then the exact test.
//   prime:    per trial divisor a check, N remainder steps and a test,
//             divisors 2..floor(sqrt); the bit-serial remainder unit takes
//             one bit per cycle.
// The output register parts the two sides: a new word is accepted while a
// result waits; the block only waits when it must load a new result while
// the old one is still stalled.
// Reset (rst, synchronous) clears filter_mode to even, the controller to
// idle and out_valid; no clearing pass is needed.
`default_nettype none

module number_property_filter
  import npf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] passed_value
);

  npf_cmd_t    cmd;
  npf_status_t status;

  // sequencer: owns the handshake on the input side and the verdict
  npf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: mode register, trial divider, root unit, output register
  npf_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .value        (value),
    .passed_value (passed_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

[hdl/npf_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module npf_checker #(
  parameter int VALUE_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [VALUE_BITS-1:0] passed_value
);

  // a stalled result holds
  `NPF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(passed_value), "stalled result changed")

  // one word at a time: busy right after an accept
  `NPF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted a second word while busy")

  // a result never appears in the cycle after an accept
  `NPF_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && !in_stall, !$rose(out_valid), "result too early")

  // results are loaded only while the input side is held off
  `NPF_ASSERT_SAME(a_emit_while_busy, clk, rst, $rose(out_valid), $past(in_stall), "result loaded while idle")

endmodule

bind number_property_filter npf_checker #(.VALUE_BITS(VALUE_BITS)) u_npf_checker (.*);

`default_nettype wire
